// File: sv/scc_pkg.sv
package scc_pkg;

  // Widths fixed by the request and result fields.
  localparam int unsigned SEC_W   = 10;
  localparam int unsigned FILE_W  = 6;
  localparam int unsigned BYTES_W = 18;
  localparam int unsigned EPOCH_W = 8;

  // Sector trailer layout and count limits.
  localparam int unsigned TRAILER_BYTES = 3;
  localparam logic [7:0]  LIMIT_SMALL   = 8'(128 - TRAILER_BYTES);
  localparam logic [7:0]  LIMIT_LARGE   = 8'(256 - TRAILER_BYTES);

  // Configuration register indexes.
  localparam logic REG_SIZE_MODE    = 1'b0;
  localparam logic REG_SECTOR_TOTAL = 1'b1;

  localparam logic [SEC_W-1:0] SECTOR_TOTAL_RESET = 10'd720;

  // Walk status codes as reported on the result channel.
  typedef enum logic [2:0] {
    ST_WALK  = 3'd0,
    ST_END   = 3'd1,
    ST_RANGE = 3'd2,
    ST_LOOP  = 3'd3,
    ST_OWNER = 3'd4,
    ST_COUNT = 3'd5
  } status_e;

  // One write into the visited map: sector index and the epoch that marks it.
  typedef struct packed {
    logic               en;
    logic [SEC_W-1:0]   idx;
    logic [EPOCH_W-1:0] tag;
  } map_wr_t;

endpackage

// File: sv/scc_visit_mem.sv
module scc_visit_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_req_i,
  output logic                          busy_o,
  input  scc_pkg::map_wr_t              wr_i,
  input  logic                          rd_en_i,
  input  logic [scc_pkg::SEC_W-1:0]     rd_idx_i,
  output logic [scc_pkg::EPOCH_W-1:0]   rd_tag_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [scc_pkg::EPOCH_W-1:0] mem [DEPTH];
  logic [AW-1:0]               clr_cnt_q;
  logic                        busy_q;
  logic [scc_pkg::EPOCH_W-1:0] rd_tag_q;

  // Clearing sweep: runs after reset and whenever the epoch counter wraps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == LAST) begin
        busy_q    <= 1'b0;
        clr_cnt_q <= '0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end else if (clr_req_i) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end
  end

  // Single write port, shared between the sweep and sector marking.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_i.en) begin
      mem[wr_i.idx[AW-1:0]] <= wr_i.tag;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_tag_q <= mem[rd_idx_i[AW-1:0]];
    end
  end

  assign busy_o   = busy_q;
  assign rd_tag_o = rd_tag_q;

endmodule

// File: sv/sector_chain_checker.sv
// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_ready_o    mode, file_number, first_sector, trailer bytes
// out       result     out_valid_o / out_ready_i  request_sector, sectors_seen, bytes_total,
//                                                 status, done_res
// cfg       APB write  psel, penable, pwrite      sector_size_mode, disk_sector_total
//
// One request per cycle unless the map is being swept or the result register is stalled.
// An input stage that also reads the visited map feeds a result register. Each request
// marks at most one sector through the single map write port, so marking never limits
// the rate. After reset all MAX_SECTORS map entries are swept with in_ready_o low.
// Every 255 chain starts the epoch counter wraps and the map is swept again, which
// holds the start until the sweep ends. A stalled result register stalls the input.
module sector_chain_checker #(
  parameter int unsigned MAX_SECTORS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [scc_pkg::FILE_W-1:0]    file_number_i,
  input  logic [scc_pkg::SEC_W-1:0]     first_sector_i,
  input  logic [7:0]                    link_high_byte_i,
  input  logic [7:0]                    link_low_byte_i,
  input  logic [7:0]                    count_byte_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [scc_pkg::SEC_W-1:0]     request_sector_o,
  output logic [scc_pkg::SEC_W-1:0]     sectors_seen_o,
  output logic [scc_pkg::BYTES_W-1:0]   bytes_total_o,
  output logic [2:0]                    status_o,
  output logic                          done_res_o
);

  localparam int unsigned SW = scc_pkg::SEC_W;
  localparam int unsigned EW = scc_pkg::EPOCH_W;
  localparam int unsigned BW = scc_pkg::BYTES_W;
  localparam logic [SW:0] MAX_L = (SW + 1)'(MAX_SECTORS);

  // Configuration registers.
  logic          size_mode_q;
  logic [SW-1:0] sector_total_q;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_mode_q    <= 1'b0;
      sector_total_q <= scc_pkg::SECTOR_TOTAL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        scc_pkg::REG_SIZE_MODE:    size_mode_q    <= pwdata[0];
        scc_pkg::REG_SECTOR_TOTAL: sector_total_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      scc_pkg::REG_SIZE_MODE:    prdata = {31'd0, size_mode_q};
      scc_pkg::REG_SECTOR_TOTAL: prdata = {{(32 - SW){1'b0}}, sector_total_q};
      default:                   prdata = '0;
    endcase
  end

  // Walk state.
  logic                       walking_q, walking_d;
  logic [scc_pkg::FILE_W-1:0] owner_q, owner_d;
  logic [SW-1:0]              pending_d;
  logic [SW-1:0]              sect_q, sect_d;
  logic [BW-1:0]              bytes_q, bytes_d;
  scc_pkg::status_e           held_q, status_d;
  logic [EW-1:0]              epoch_q, epoch_d;

  // Input stage registers.
  logic          s1_valid_q;
  logic          s1_mode_q;
  logic [scc_pkg::FILE_W-1:0] s1_file_q;
  logic [SW-1:0] s1_first_q;
  logic [7:0]    s1_hi_q, s1_lo_q, s1_cnt_q;
  logic          s1_byp_q;
  logic [EW-1:0] s1_tag;

  // Result register.
  logic          out_valid_q;
  logic [SW-1:0] out_req_q, out_sect_q;
  logic [BW-1:0] out_bytes_q;
  scc_pkg::status_e out_status_q;

  logic             busy, clr_req, wrap, out_free, s1_adv, in_acc;
  scc_pkg::map_wr_t map_wr;

  // Stage 0: address the visited map with the next link of the incoming trailer.
  logic [SW-1:0] in_next, in_idx, rd_idx;
  logic          byp_d;

  assign in_next = {link_high_byte_i[1:0], link_low_byte_i};
  assign in_idx  = in_next - 1'b1;
  assign rd_idx  = ({1'b0, in_idx} < MAX_L) ? in_idx : '0;
  // A sector marked by the item leaving stage 1 is not yet visible in the read data.
  assign byp_d   = map_wr.en && (map_wr.idx == rd_idx);

  assign out_free   = !out_valid_q || out_ready_i;
  assign wrap       = s1_valid_q && !s1_mode_q && (epoch_q == {EW{1'b1}});
  assign clr_req    = wrap && !busy;
  assign s1_adv     = s1_valid_q && !busy && !wrap && out_free;
  assign in_ready_o = !busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q  <= mode_i;
      s1_file_q  <= file_number_i;
      s1_first_q <= first_sector_i;
      s1_hi_q    <= link_high_byte_i;
      s1_lo_q    <= link_low_byte_i;
      s1_cnt_q   <= count_byte_i;
      s1_byp_q   <= byp_d;
    end
  end

  scc_visit_mem #(
    .DEPTH (MAX_SECTORS)
  ) u_visit_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_req_i (clr_req),
    .busy_o    (busy),
    .wr_i      (map_wr),
    .rd_en_i   (in_acc),
    .rd_idx_i  (rd_idx),
    .rd_tag_o  (s1_tag)
  );

  // Stage 1: decode the trailer, run the checks and update the tallies.
  logic [SW-1:0] target;
  logic [7:0]    count, limit;
  logic [BW:0]   bytes_sum;
  logic          out_of_range, visited;

  always_comb begin
    count     = size_mode_q ? s1_cnt_q : {1'b0, s1_cnt_q[6:0]};
    limit     = size_mode_q ? scc_pkg::LIMIT_LARGE : scc_pkg::LIMIT_SMALL;
    target    = s1_mode_q ? {s1_hi_q[1:0], s1_lo_q} : s1_first_q;
    bytes_sum = {1'b0, bytes_q} + {{(BW - 7){1'b0}}, count};
    out_of_range = (target > sector_total_q) || ({1'b0, target} > MAX_L);
    visited   = s1_byp_q || (s1_tag == epoch_q);

    epoch_d   = epoch_q;
    owner_d   = owner_q;
    sect_d    = sect_q;
    bytes_d   = bytes_q;
    status_d  = held_q;
    map_wr.en = 1'b0;

    if (!s1_mode_q) begin
      // Chain start: a fresh epoch empties the visited map.
      epoch_d  = epoch_q + 1'b1;
      owner_d  = s1_file_q;
      sect_d   = '0;
      bytes_d  = '0;
      if (target == '0) begin
        status_d = scc_pkg::ST_END;
      end else if (out_of_range) begin
        status_d = scc_pkg::ST_RANGE;
      end else begin
        status_d = scc_pkg::ST_WALK;
      end
    end else if (walking_q) begin
      if (s1_hi_q[7:2] != owner_q) begin
        status_d = scc_pkg::ST_OWNER;
      end else if (count > limit) begin
        status_d = scc_pkg::ST_COUNT;
      end else begin
        // Accepted sector: saturating tallies, then follow the link.
        if (sect_q != {SW{1'b1}}) begin
          sect_d = sect_q + 1'b1;
        end
        bytes_d = bytes_sum[BW] ? {BW{1'b1}} : bytes_sum[BW-1:0];
        if (target == '0) begin
          status_d = scc_pkg::ST_END;
        end else if (out_of_range) begin
          status_d = scc_pkg::ST_RANGE;
        end else if (visited) begin
          status_d = scc_pkg::ST_LOOP;
        end else begin
          status_d = scc_pkg::ST_WALK;
        end
      end
    end

    walking_d  = (status_d == scc_pkg::ST_WALK);
    pending_d  = walking_d ? target : '0;
    map_wr.en  = s1_adv && walking_d;
    map_wr.idx = target - 1'b1;
    map_wr.tag = epoch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q <= 1'b0;
      owner_q   <= '0;
      sect_q    <= '0;
      bytes_q   <= '0;
      held_q    <= scc_pkg::ST_END;
      epoch_q   <= '0;
    end else if (clr_req) begin
      epoch_q <= '0;
    end else if (s1_adv) begin
      walking_q <= walking_d;
      owner_q   <= owner_d;
      sect_q    <= sect_d;
      bytes_q   <= bytes_d;
      held_q    <= status_d;
      epoch_q   <= epoch_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_req_q    <= pending_d;
      out_sect_q   <= sect_d;
      out_bytes_q  <= bytes_d;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign request_sector_o = out_req_q;
  assign sectors_seen_o   = out_sect_q;
  assign bytes_total_o    = out_bytes_q;
  assign status_o         = out_status_q;
  assign done_res_o       = (out_status_q != scc_pkg::ST_WALK);

  // The sweep owns the map write port.
  a_no_write_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !map_wr.en)
    else $error("visited map written during clearing sweep");

  // No request enters while the map is being swept.
  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !busy)
    else $error("request accepted during clearing sweep");

  // An epoch wrap starts a sweep and leaves the start request waiting.
  a_wrap_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_req |=> (busy && s1_valid_q && (epoch_q == '0)))
    else $error("epoch wrap did not start a sweep");

  // A walking result always names a nonzero sector to fetch.
  a_walk_requests_sector : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == scc_pkg::ST_WALK)) |-> (out_req_q != '0))
    else $error("walking result without a sector request");

endmodule

// File: test/scc_tb_pkg.sv
`timescale 1ns / 100ps
package scc_tb_pkg;

  // Request kinds carried on the mode field.
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_TRAILER = 1'b1;

  // Values of the sector size register.
  localparam logic SIZE_SMALL = 1'b0;
  localparam logic SIZE_LARGE = 1'b1;

  // Byte addresses of the configuration registers.
  localparam logic [2:0] ADDR_SIZE_MODE    = {scc_pkg::REG_SIZE_MODE, 2'b00};
  localparam logic [2:0] ADDR_SECTOR_TOTAL = {scc_pkg::REG_SECTOR_TOTAL, 2'b00};

endpackage

// File: test/chain_walk_checker.sv
`timescale 1ns / 100ps
module chain_walk_checker #(
  parameter int unsigned MAX_SECTORS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port, watched only
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  // request channel
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic                          mode_i,
  input  logic [scc_pkg::FILE_W-1:0]    file_number_i,
  input  logic [scc_pkg::SEC_W-1:0]     first_sector_i,
  input  logic [7:0]                    link_high_byte_i,
  input  logic [7:0]                    link_low_byte_i,
  input  logic [7:0]                    count_byte_i,
  // result channel
  input  logic                          res_valid_i,
  input  logic                          res_ready_i,
  input  logic [scc_pkg::SEC_W-1:0]     request_sector_i,
  input  logic [scc_pkg::SEC_W-1:0]     sectors_seen_i,
  input  logic [scc_pkg::BYTES_W-1:0]   bytes_total_i,
  input  logic [2:0]                    status_i,
  input  logic                          done_res_i,
  // verdict inputs for the top
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned SEC_W       = scc_pkg::SEC_W;
  localparam int unsigned FILE_W      = scc_pkg::FILE_W;
  localparam int unsigned BYTES_W     = scc_pkg::BYTES_W;
  localparam int unsigned SECTOR_SPAN = 1 << SEC_W;

  typedef struct packed {
    logic [SEC_W-1:0]   request_sector;
    logic [SEC_W-1:0]   sectors_seen;
    logic [BYTES_W-1:0] bytes_total;
    logic [2:0]         status;
    logic               done;
  } walk_result_t;

  // Mirror of the registers and of the walk state.
  logic                   cfg_size;
  logic [SEC_W-1:0]       cfg_total;
  logic [SECTOR_SPAN-1:0] chain_marks;
  logic [FILE_W-1:0]      chain_owner;
  logic [SEC_W-1:0]       chain_next;
  logic [SEC_W-1:0]       chain_sectors;
  logic [BYTES_W-1:0]     chain_bytes;
  logic                   chain_walking;
  scc_pkg::status_e       chain_status;

  walk_result_t           walk_results_q[$];
  int                     mismatch_total;

  // Range check, then loop check; a good sector is marked and becomes the next request.
  function automatic scc_pkg::status_e claim_sector(logic [SEC_W-1:0] sec);
    if (sec > cfg_total || 32'(sec) > MAX_SECTORS) return scc_pkg::ST_RANGE;
    if (chain_marks[sec]) return scc_pkg::ST_LOOP;
    chain_marks[sec] = 1'b1;
    chain_next = sec;
    return scc_pkg::ST_WALK;
  endfunction

  // Latches the status and forms the result that goes out for it.
  function automatic walk_result_t finish_step(scc_pkg::status_e st);
    walk_result_t r;
    chain_status = st;
    chain_walking = (st == scc_pkg::ST_WALK);
    if (!chain_walking) chain_next = '0;
    r.request_sector = chain_next;
    r.sectors_seen = chain_sectors;
    r.bytes_total = chain_bytes;
    r.status = st;
    r.done = !chain_walking;
    return r;
  endfunction

  // Works out the result of one request and advances the walk.
  function automatic walk_result_t predict_walk(logic md, logic [FILE_W-1:0] fnum,
                                                logic [SEC_W-1:0] first, logic [7:0] hi,
                                                logic [7:0] lo, logic [7:0] cnt);
    logic [7:0]         count;
    logic [7:0]         limit;
    logic [SEC_W-1:0]   link;
    logic [BYTES_W:0]   sum;
    if (md == scc_tb_pkg::MODE_START) begin
      chain_marks = '0;
      chain_owner = fnum;
      chain_sectors = '0;
      chain_bytes = '0;
      chain_next = '0;
      if (first == '0) return finish_step(scc_pkg::ST_END);
      return finish_step(claim_sector(first));
    end
    // A trailer with no walk in progress only repeats the last outcome.
    if (!chain_walking) return finish_step(chain_status);
    count = (cfg_size == scc_tb_pkg::SIZE_LARGE) ? cnt : {1'b0, cnt[6:0]};
    limit = (cfg_size == scc_tb_pkg::SIZE_LARGE) ? scc_pkg::LIMIT_LARGE
                                                 : scc_pkg::LIMIT_SMALL;
    link = {hi[1:0], lo};
    if (hi[7:2] != chain_owner) return finish_step(scc_pkg::ST_OWNER);
    if (count > limit) return finish_step(scc_pkg::ST_COUNT);
    if (chain_sectors != '1) chain_sectors = chain_sectors + 1'b1;
    sum = {1'b0, chain_bytes} + {{(BYTES_W - 7){1'b0}}, count};
    chain_bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
    if (link == '0) return finish_step(scc_pkg::ST_END);
    return finish_step(claim_sector(link));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    walk_result_t got;
    walk_result_t want;
    walk_result_t fresh;
    if (!rst_ni) begin
      cfg_size = scc_tb_pkg::SIZE_SMALL;
      cfg_total = scc_pkg::SECTOR_TOTAL_RESET;
      chain_marks = '0;
      chain_owner = '0;
      chain_next = '0;
      chain_sectors = '0;
      chain_bytes = '0;
      chain_walking = 1'b0;
      chain_status = scc_pkg::ST_END;
      walk_results_q.delete();
      mismatch_total = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // Results are checked before new requests are predicted.
      if (res_valid_i && res_ready_i) begin
        got.request_sector = request_sector_i;
        got.sectors_seen = sectors_seen_i;
        got.bytes_total = bytes_total_i;
        got.status = status_i;
        got.done = done_res_i;
        if (walk_results_q.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: result with no request outstanding: req %0d status %0d",
                     $realtime, got.request_sector, got.status);
          mismatch_total++;
        end else begin
          want = walk_results_q.pop_front();
          if (got.request_sector !== want.request_sector ||
              got.sectors_seen !== want.sectors_seen ||
              got.bytes_total !== want.bytes_total ||
              got.status !== want.status ||
              got.done !== want.done) begin
            if (mismatch_total < 10)
              $display("%0t: req/seen/bytes/status/done exp %0d/%0d/%0d/%0d/%0d",
                       $realtime, want.request_sector, want.sectors_seen,
                       want.bytes_total, want.status, want.done,
                       " got %0d/%0d/%0d/%0d/%0d", got.request_sector,
                       got.sectors_seen, got.bytes_total, got.status, got.done);
            mismatch_total++;
          end
        end
      end

      // Register writes.
      if (psel && penable && pwrite && pready) begin
        if (paddr == scc_tb_pkg::ADDR_SIZE_MODE) cfg_size = pwdata[0];
        else if (paddr == scc_tb_pkg::ADDR_SECTOR_TOTAL) cfg_total = pwdata[SEC_W-1:0];
      end

      if (req_valid_i && req_ready_i) begin
        fresh = predict_walk(mode_i, file_number_i, first_sector_i,
                             link_high_byte_i, link_low_byte_i, count_byte_i);
        walk_results_q = {walk_results_q, fresh};
      end

      pending_o <= walk_results_q.size();
      fail_count_o <= mismatch_total;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int unsigned SEC_W   = scc_pkg::SEC_W;
  localparam int unsigned FILE_W  = scc_pkg::FILE_W;
  localparam int unsigned BYTES_W = scc_pkg::BYTES_W;

  localparam int WATCHDOG_LIMIT = 8000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 190;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 mode_i;
  logic [FILE_W-1:0]    file_number_i;
  logic [SEC_W-1:0]     first_sector_i;
  logic [7:0]           link_high_byte_i;
  logic [7:0]           link_low_byte_i;
  logic [7:0]           count_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [SEC_W-1:0]     request_sector_o;
  logic [SEC_W-1:0]     sectors_seen_o;
  logic [BYTES_W-1:0]   bytes_total_o;
  logic [2:0]           status_o;
  logic                 done_res_o;

  int                   fail_count;
  int                   results_pending;

  // Stimulus planning state: current settings and the chain being walked.
  logic                 cur_size;
  logic [SEC_W-1:0]     cur_total;
  logic                 quiet;
  logic                 hold_out_req;
  logic                 walk_open;
  logic [FILE_W-1:0]    walk_file;
  logic [SEC_W-1:0]     walk_first;
  logic [1023:0]        walk_used;
  int                   walk_left;
  int                   items_sent;
  int                   idle_cycles = 0;
  int                   stall_left;

  sector_chain_checker uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .file_number_i    (file_number_i),
    .first_sector_i   (first_sector_i),
    .link_high_byte_i (link_high_byte_i),
    .link_low_byte_i  (link_low_byte_i),
    .count_byte_i     (count_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .request_sector_o (request_sector_o),
    .sectors_seen_o   (sectors_seen_o),
    .bytes_total_o    (bytes_total_o),
    .status_o         (status_o),
    .done_res_o       (done_res_o)
  );

  chain_walk_checker walk_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .req_valid_i      (in_valid_i),
    .req_ready_i      (in_ready_o),
    .mode_i           (mode_i),
    .file_number_i    (file_number_i),
    .first_sector_i   (first_sector_i),
    .link_high_byte_i (link_high_byte_i),
    .link_low_byte_i  (link_low_byte_i),
    .count_byte_i     (count_byte_i),
    .res_valid_i      (out_valid_o),
    .res_ready_i      (out_ready_i),
    .request_sector_i (request_sector_o),
    .sectors_seen_i   (sectors_seen_o),
    .bytes_total_i    (bytes_total_o),
    .status_i         (status_o),
    .done_res_i       (done_res_o),
    .fail_count_o     (fail_count),
    .pending_o        (results_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one; none in quiet phases.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 25);
  endfunction

  // A sector in range that this chain has not used yet, or zero to end the chain.
  function automatic logic [SEC_W-1:0] fresh_sector();
    logic [SEC_W-1:0] s;
    for (int i = 0; i < 8; i++) begin
      s = SEC_W'($urandom_range(int'(cur_total), 1));
      if (!walk_used[s]) return s;
    end
    return '0;
  endfunction

  // Offers one request after a random gap and returns at the falling edge after it
  // is taken. Valid stays high so that a following request can go out back to back.
  task automatic send_request(input logic md, input logic [FILE_W-1:0] fnum,
                              input logic [SEC_W-1:0] first, input logic [7:0] hi,
                              input logic [7:0] lo, input logic [7:0] cnt);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    file_number_i <= fnum;
    first_sector_i <= first;
    link_high_byte_i <= hi;
    link_low_byte_i <= lo;
    count_byte_i <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [FILE_W-1:0] fnum, input logic [SEC_W-1:0] first);
    send_request(scc_tb_pkg::MODE_START, fnum, first, 8'($urandom()), 8'($urandom()),
                 8'($urandom()));
  endtask

  task automatic send_trailer(input logic [FILE_W-1:0] owner, input logic [SEC_W-1:0] link,
                              input logic [7:0] cnt);
    send_request(scc_tb_pkg::MODE_TRAILER, FILE_W'($urandom()), SEC_W'($urandom()),
                 {owner, link[9:8]}, link[7:0], cnt);
  endtask

  task automatic send_noise();
    send_request(scc_tb_pkg::MODE_TRAILER, FILE_W'($urandom()), SEC_W'($urandom()),
                 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  // Lowers valid and waits until every result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
  endtask

  // Setup and access cycle of one write; the caller closes the transfer.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Registers change only with nothing in flight.
  task automatic set_config(input logic size, input logic [SEC_W-1:0] total);
    drain_results();
    repeat (4) @(negedge clk_i);
    write_reg(scc_tb_pkg::ADDR_SIZE_MODE, 32'(size));
    write_reg(scc_tb_pkg::ADDR_SECTOR_TOTAL, 32'(total));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    cur_size = size;
    cur_total = total;
  endtask

  // Opens a chain; now and then an empty file or a first sector out of range.
  task automatic start_chain();
    int r;
    logic [SEC_W-1:0] first;
    r = $urandom_range(99);
    walk_used = '0;
    walk_file = FILE_W'($urandom());
    walk_left = ($urandom_range(19) == 0) ? $urandom_range(120, 20) : $urandom_range(6, 1);
    if (r < 5) first = '0;
    else if (r < 10 && cur_total < 10'd1023)
      first = SEC_W'($urandom_range(1023, int'(cur_total) + 1));
    else first = SEC_W'($urandom_range(int'(cur_total), 1));
    walk_open = (first != '0) && (first <= cur_total);
    walk_used[first] = 1'b1;
    walk_first = first;
    send_start(walk_file, first);
  endtask

  // Delivers the trailer of the requested sector, well formed most of the time.
  task automatic feed_trailer();
    int r;
    logic [FILE_W-1:0] owner;
    logic [SEC_W-1:0] link;
    logic [7:0] cnt;
    r = $urandom_range(99);
    owner = walk_file;
    if (cur_size == scc_tb_pkg::SIZE_LARGE)
      cnt = 8'($urandom_range(int'(scc_pkg::LIMIT_LARGE)));
    else cnt = {1'($urandom()), 7'($urandom_range(int'(scc_pkg::LIMIT_SMALL)))};
    link = (walk_left <= 1) ? '0 : fresh_sector();
    walk_left--;
    if (r < 2) begin
      owner = walk_file ^ FILE_W'($urandom_range(63, 1));
    end else if (r < 4) begin
      if (cur_size == scc_tb_pkg::SIZE_LARGE)
        cnt = 8'($urandom_range(255, int'(scc_pkg::LIMIT_LARGE) + 1));
      else
        cnt = {1'($urandom()), 7'($urandom_range(127, int'(scc_pkg::LIMIT_SMALL) + 1))};
    end else if (r < 6 && cur_total < 10'd1023) begin
      link = SEC_W'($urandom_range(1023, int'(cur_total) + 1));
    end else if (r < 8) begin
      link = walk_first;
    end
    if (r < 8 || link == '0) walk_open = 1'b0;
    walk_used[link] = 1'b1;
    send_trailer(owner, link, cnt);
  endtask

  // Result side: random stalls, plus one long hold-off whenever it is asked for.
  initial begin
    out_ready_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (hold_out_req) begin
        out_ready_i <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
        hold_out_req = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [SEC_W-1:0] total;
    int phase_end;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mode_i = scc_tb_pkg::MODE_START;
    file_number_i = '0;
    first_sector_i = '0;
    link_high_byte_i = '0;
    link_low_byte_i = '0;
    count_byte_i = '0;
    quiet = 1'b0;
    hold_out_req = 1'b0;
    walk_open = 1'b0;
    walk_used = '0;
    walk_file = '0;
    walk_first = '0;
    walk_left = 0;
    items_sent = 0;
    cur_size = scc_tb_pkg::SIZE_SMALL;
    cur_total = scc_pkg::SECTOR_TOTAL_RESET;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset settings: empty file, idle trailers, first sector
    // out of range, the count limit with bit 7 ignored, owner mismatch and a loop.
    send_start(6'd0, 10'd0);
    send_trailer(6'd63, 10'd1023, 8'hFF);
    send_start(6'd63, 10'd1023);
    send_start(6'd21, 10'd721);
    send_trailer(6'd0, 10'd0, 8'h00);
    send_start(6'd63, 10'd720);
    send_trailer(6'd63, 10'd1, 8'hFD);
    send_trailer(6'd63, 10'd2, 8'h7E);
    send_start(6'd10, 10'd3);
    send_trailer(6'd11, 10'd4, 8'h00);
    send_start(6'd10, 10'd3);
    send_trailer(6'd10, 10'd3, 8'h80);
    send_start(6'd42, 10'd2);
    send_trailer(6'd42, 10'd5, 8'd100);
    send_trailer(6'd42, 10'd0, 8'd0);

    // Large sectors over the whole disk, then size and range changed mid-walk.
    set_config(scc_tb_pkg::SIZE_LARGE, 10'd1023);
    send_start(6'd0, 10'd1023);
    send_trailer(6'd0, 10'd1, 8'd253);
    send_trailer(6'd0, 10'd1023, 8'd0);
    send_start(6'd33, 10'd1);
    send_trailer(6'd33, 10'd1023, 8'd254);
    send_start(6'd33, 10'd512);
    set_config(scc_tb_pkg::SIZE_SMALL, 10'd1023);
    send_trailer(6'd33, 10'd700, 8'hFD);
    set_config(scc_tb_pkg::SIZE_LARGE, 10'd600);
    send_trailer(6'd33, 10'd1000, 8'd200);
    send_trailer(6'd33, 10'd0, 8'd0);

    // Random phases, each under its own settings; a walk may stay open across one.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: total = 10'd1023;
        1: total = SEC_W'($urandom_range(16, 2));
        2: total = SEC_W'($urandom_range(1023, 1));
        default: total = 10'd1;
      endcase
      set_config(p[0] ^ p[2], total);
      quiet = (p % 4 == 2);
      if (p % 4 == 0) hold_out_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (walk_open) begin
          feed_trailer();
        end else begin
          if ($urandom_range(15) == 0) send_noise();
          start_chain();
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
